FILE: rtl/ecg_delta_packet_encoder_core_macros.svh
// ============================================================================
// ecg delta packet encoder - assertion macros
// Shared property shorthands; every use samples on i_clk and is idle in reset.
// ============================================================================
`ifndef ECG_DELTA_PACKET_ENCODER_CORE_MACROS_SVH
`define ECG_DELTA_PACKET_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define ECGDPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECGDPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ecgdpe_pkg.sv
// ============================================================================
// ecgdpe_pkg
// Types and constants shared by the ecg delta packet encoder modules.
// ============================================================================
`default_nettype none

package ecgdpe_pkg;

    localparam int DELTA_POINTS = 13;
    localparam int GROUP_LEN    = DELTA_POINTS + 1;
    localparam int PACKET_LEN   = DELTA_POINTS + 7;
    localparam int CNT_W        = $clog2(GROUP_LEN);
    localparam int ADDR_W       = CNT_W + 1;
    localparam int MEM_DEPTH    = 2 ** ADDR_W;
    localparam int PKT_CNT_W    = $clog2(PACKET_LEN);

    localparam int SAMPLE_W = 16;
    localparam int ID_W     = 16;
    localparam int HR_W     = 8;
    localparam int BYTE_W   = 8;
    localparam int DELTA_W  = 17;
    localparam int MAG_W    = 16;
    localparam int SCALE_W  = 10;
    localparam int QUO_W    = 8;

    // divide by 127 as (n * 66053) >> 23, exact for n below 2**16
    localparam int RECIP_W  = 17;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int RECIP_SH = PROD_W - SCALE_W;
    localparam logic [RECIP_W-1:0] RECIP_127 = 17'd66053;

    localparam int DIV_CYCLES = QUO_W / 2;
    localparam int STEP_W     = $clog2(DIV_CYCLES);

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [SCALE_W-1:0] SCALE_KNEE = 10'd100;
    localparam logic [BYTE_W-1:0]  PKT_TYPE   = 8'd1;
    localparam logic [BYTE_W-1:0]  BYTE_BIAS  = 8'd128;
    localparam logic [BYTE_W-1:0]  MAX_CODE   = 8'd204;

    localparam logic [CNT_W-1:0]     LAST_CNT      = CNT_W'(DELTA_POINTS);
    localparam logic [CNT_W-1:0]     LAST_SLOT     = CNT_W'(DELTA_POINTS - 1);
    localparam logic [PKT_CNT_W-1:0] LAST_BYTE_IDX = PKT_CNT_W'(PACKET_LEN - 1);
    localparam logic [PKT_CNT_W-1:0] CODE_BYTE_IDX = PKT_CNT_W'(3);

    typedef struct packed {
        logic                bank;
        logic [SAMPLE_W-1:0] reference;
        logic [ID_W-1:0]     data_id;
        logic [HR_W-1:0]     heart_rate;
        logic [MAG_W-1:0]    rise;
        logic [MAG_W-1:0]    fall_mag;
    } t_desc;

    typedef struct packed {
        logic               vld;
        logic [ADDR_W-1:0]  addr;
        logic [DELTA_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic vld;
        logic bank;
    } t_rel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_HDR,
        S_RD,
        S_LD,
        S_DIV,
        S_EMIT,
        S_HR
    } t_bstate;

    typedef enum logic [2:0] {
        H_TYPE,
        H_ID_HI,
        H_ID_LO,
        H_CODE,
        H_REF_HI,
        H_REF_LO
    } t_hdr;

endpackage

`default_nettype wire

FILE: rtl/ecg_delta_packet_encoder_core.sv
// ============================================================================
// ecg_delta_packet_encoder_core
// Groups ECG samples, scales their deltas and streams 20-byte packets.
// ============================================================================
// Input channel (i_in_valid / o_in_ready): one request per sample with its
// data id and heart rate; groups of 14 samples, the last one's id and rate
// go into the packet. Output channel (o_out_valid / i_out_ready): one packet
// byte per request, o_last_byte set on the 20th byte.
// Samples are taken one per cycle while o_in_ready is high, into one of two
// delta banks. A finished group is queued; the packet builder then forms
// the scale, 6 header bytes, per delta a store read, operand load, then
// two-bit-per-cycle division and emit, and the heart rate. The divider sets
// the sustained rate. With the builder idle, the first byte follows the last
// sample through the queue, the idle, multiply, scale and header states and
// the output register. One further group can be taken while a packet drains.
// Reset (synchronous, active low) empties the queue, frees both banks and
// restarts grouping at the reference sample. A receiver stall holds the
// current byte; the builder and then the input side back up behind it.
// ============================================================================
`default_nettype none

module ecg_delta_packet_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ecgdpe_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [ecgdpe_pkg::ID_W-1:0]     i_data_id,
    input  logic [ecgdpe_pkg::HR_W-1:0]     i_heart_rate,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ecgdpe_pkg::BYTE_W-1:0]   o_packet_byte,
    output logic                            o_last_byte
);
    import ecgdpe_pkg::*;

    t_rel  w_rel;
    t_wr   w_wr;
    t_desc w_push_desc;
    t_desc w_pop_desc;
    logic  w_push;
    logic  w_push_ready;
    logic  w_pop;
    logic  w_pop_valid;

    ecgdpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_data_id    (i_data_id),
        .i_heart_rate (i_heart_rate),
        .i_rel        (w_rel),
        .i_push_ready (w_push_ready),
        .o_push       (w_push),
        .o_desc       (w_push_desc),
        .o_wr         (w_wr)
    );

    ecgdpe_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_desc       (w_push_desc),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_desc       (w_pop_desc),
        .i_pop        (w_pop)
    );

    ecgdpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_pop_valid   (w_pop_valid),
        .i_desc        (w_pop_desc),
        .o_pop         (w_pop),
        .o_rel         (w_rel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packet_byte (o_packet_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

`default_nettype wire

FILE: rtl/ecgdpe_front.sv
// ============================================================================
// ecgdpe_front
// Takes samples, forms deltas into the banked store, tracks the extremes and
// queues one descriptor per finished group.
// ============================================================================
`default_nettype none

module ecgdpe_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ecgdpe_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [ecgdpe_pkg::ID_W-1:0]      i_data_id,
    input  logic [ecgdpe_pkg::HR_W-1:0]      i_heart_rate,
    input  ecgdpe_pkg::t_rel                 i_rel,
    input  logic                             i_push_ready,
    output logic                             o_push,
    output ecgdpe_pkg::t_desc                o_desc,
    output ecgdpe_pkg::t_wr                  o_wr
);
    import ecgdpe_pkg::*;

    logic [CNT_W-1:0]           r_cnt;
    logic                       r_bank;
    logic [1:0]                 r_busy;
    logic [SAMPLE_W-1:0]        r_prev;
    logic [SAMPLE_W-1:0]        r_ref;
    logic signed [DELTA_W-1:0]  r_rise;
    logic signed [DELTA_W-1:0]  r_fall;

    logic [CNT_W-1:0]           n_cnt;
    logic [1:0]                 n_busy;
    logic signed [DELTA_W-1:0]  n_rise;
    logic signed [DELTA_W-1:0]  n_fall;
    logic signed [DELTA_W-1:0]  w_dv;
    logic signed [DELTA_W-1:0]  w_neg_fall;
    logic                       w_last;
    logic                       w_first;
    logic                       w_acc;

    always_comb begin
        w_last     = (r_cnt == LAST_CNT);
        w_first    = (r_cnt == '0);
        // a group may start only into a bank the back has released
        o_in_ready = !r_busy[r_bank] && (!w_last || i_push_ready);
        w_acc      = i_in_valid && o_in_ready;

        w_dv = $signed({i_sample[SAMPLE_W-1], i_sample})
             - $signed({r_prev[SAMPLE_W-1], r_prev});

        if (w_first) begin
            n_rise = '0;
            n_fall = '0;
        end else begin
            n_rise = (w_dv > r_rise) ? w_dv : r_rise;
            n_fall = (w_dv < r_fall) ? w_dv : r_fall;
        end
        w_neg_fall = -n_fall;

        n_cnt = w_last ? '0 : r_cnt + CNT_W'(1);

        n_busy = r_busy;
        if (i_rel.vld) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (w_acc && w_last) begin
            n_busy[r_bank] = 1'b1;
        end

        o_wr.vld  = w_acc && !w_first;
        o_wr.addr = {r_bank, r_cnt - CNT_W'(1)};
        o_wr.data = w_dv;

        o_push            = w_acc && w_last;
        o_desc.bank       = r_bank;
        o_desc.reference  = r_ref;
        o_desc.data_id    = i_data_id;
        o_desc.heart_rate = i_heart_rate;
        o_desc.rise       = n_rise[MAG_W-1:0];
        o_desc.fall_mag   = w_neg_fall[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
            if (w_acc) begin
                r_cnt <= n_cnt;
                if (w_last) begin
                    r_bank <= ~r_bank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_prev <= i_sample;
            r_rise <= n_rise;
            r_fall <= n_fall;
            if (w_first) begin
                r_ref <= i_sample;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ecgdpe_fifo.sv
// ============================================================================
// ecgdpe_fifo
// Short descriptor queue between the sample front and the packet back.
// ============================================================================
`default_nettype none

module ecgdpe_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ecgdpe_pkg::t_desc i_desc,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output ecgdpe_pkg::t_desc o_desc,
    input  logic              i_pop
);
    import ecgdpe_pkg::*;

    t_desc            r_q [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;

    logic w_push;
    logic w_pop;

    always_comb begin
        o_push_ready = (r_cnt != (PTR_W+1)'(FIFO_DEPTH));
        o_pop_valid  = (r_cnt != '0);
        o_desc       = r_q[r_rp];
        w_push       = i_push && o_push_ready;
        w_pop        = i_pop && o_pop_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ecgdpe_back.sv
// ============================================================================
// ecgdpe_back
// Builds one packet per descriptor: scale, header, scaled deltas through a
// two-bit-per-cycle divider, heart rate; holds the delta store.
// ============================================================================
`default_nettype none

module ecgdpe_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ecgdpe_pkg::t_wr                i_wr,
    input  logic                           i_pop_valid,
    input  ecgdpe_pkg::t_desc              i_desc,
    output logic                           o_pop,
    output ecgdpe_pkg::t_rel               o_rel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ecgdpe_pkg::BYTE_W-1:0]  o_packet_byte,
    output logic                           o_last_byte
);
    import ecgdpe_pkg::*;

    logic [DELTA_W-1:0] r_mem [MEM_DEPTH];
    logic [DELTA_W-1:0] r_rdata;

    t_bstate             r_state, n_state;
    t_desc               r_desc;
    logic [PROD_W-1:0]   r_prod_p, r_prod_n;
    logic [SCALE_W-1:0]  r_scale, n_scale;
    logic [BYTE_W-1:0]   r_code, n_code;
    t_hdr                r_hidx, n_hidx;
    logic [CNT_W-1:0]    r_slot, n_slot;
    logic                r_neg, n_neg;
    logic [SCALE_W-1:0]  r_p, n_p;
    logic [QUO_W-1:0]    r_lo, n_lo;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [BYTE_W-1:0]   r_qbyte, n_qbyte;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;

    logic [ADDR_W-1:0]   w_rd_addr;
    logic                w_load;
    logic [SCALE_W-1:0]  w_sp, w_sn, w_scale, w_over;
    logic [DELTA_W-1:0]  w_abs;
    logic [BYTE_W-1:0]   w_hdr_byte;
    logic [SCALE_W:0]    w_trial;
    logic [SCALE_W-1:0]  w_p;
    logic [QUO_W-1:0]    w_lo;
    logic                w_qbit;

    assign w_rd_addr = {r_desc.bank, r_slot};

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
        r_prod_p   <= PROD_W'(r_desc.rise) * PROD_W'(RECIP_127);
        r_prod_n   <= PROD_W'(r_desc.fall_mag) * PROD_W'(RECIP_127);
        r_scale    <= n_scale;
        r_code     <= n_code;
        r_hidx     <= n_hidx;
        r_slot     <= n_slot;
        r_neg      <= n_neg;
        r_p        <= n_p;
        r_lo       <= n_lo;
        r_step     <= n_step;
        r_qbyte    <= n_qbyte;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_scale     = r_scale;
        n_code      = r_code;
        n_hidx      = r_hidx;
        n_slot      = r_slot;
        n_neg       = r_neg;
        n_p         = r_p;
        n_lo        = r_lo;
        n_step      = r_step;
        n_qbyte     = r_qbyte;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        o_rel.vld   = 1'b0;
        o_rel.bank  = r_desc.bank;

        w_load      = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;

        // max(1 + rise/127, 1 + |fall|/127)
        w_sp    = r_prod_p[PROD_W-1:RECIP_SH] + SCALE_W'(1);
        w_sn    = r_prod_n[PROD_W-1:RECIP_SH] + SCALE_W'(1);
        w_scale = (w_sp > w_sn) ? w_sp : w_sn;
        w_over  = (w_scale - SCALE_KNEE) >> 2;

        w_abs = r_rdata[DELTA_W-1] ? -r_rdata : r_rdata;

        unique case (r_hidx)
            H_TYPE:   w_hdr_byte = PKT_TYPE;
            H_ID_HI:  w_hdr_byte = r_desc.data_id[ID_W-1 -: BYTE_W];
            H_ID_LO:  w_hdr_byte = r_desc.data_id[BYTE_W-1:0];
            H_CODE:   w_hdr_byte = r_code;
            H_REF_HI: w_hdr_byte = r_desc.reference[SAMPLE_W-1 -: BYTE_W];
            H_REF_LO: w_hdr_byte = r_desc.reference[BYTE_W-1:0];
            default:  w_hdr_byte = PKT_TYPE;
        endcase

        // restoring division, two quotient bits per cycle
        w_p  = r_p;
        w_lo = r_lo;
        for (int j = 0; j < 2; j++) begin
            w_trial = {w_p, w_lo[QUO_W-1]};
            w_qbit  = (w_trial >= {1'b0, r_scale});
            if (w_qbit) begin
                w_trial = w_trial - {1'b0, r_scale};
            end
            w_p  = w_trial[SCALE_W-1:0];
            w_lo = {w_lo[QUO_W-2:0], w_qbit};
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_scale = w_scale;
                n_code  = (w_scale > SCALE_KNEE) ? BYTE_W'(SCALE_KNEE + w_over)
                                                 : BYTE_W'(w_scale);
                n_hidx  = H_TYPE;
                n_state = S_HDR;
            end
            S_HDR: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_hdr_byte;
                    n_out_last  = 1'b0;
                    if (r_hidx == H_REF_LO) begin
                        n_slot  = '0;
                        n_state = S_RD;
                    end else begin
                        n_hidx = t_hdr'(r_hidx + 3'd1);
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                // |delta| < 128*scale, so the upper byte is already below scale
                n_neg   = r_rdata[DELTA_W-1];
                n_p     = SCALE_W'(w_abs[MAG_W-1:QUO_W]);
                n_lo    = w_abs[QUO_W-1:0];
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_p    = w_p;
                n_lo   = w_lo;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_CYCLES - 1)) begin
                    n_qbyte = r_neg ? BYTE_BIAS - w_lo : BYTE_BIAS + w_lo;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_qbyte;
                    n_out_last  = 1'b0;
                    if (r_slot == LAST_SLOT) begin
                        n_state = S_HR;
                    end else begin
                        n_slot  = r_slot + CNT_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_HR: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_desc.heart_rate;
                    n_out_last  = 1'b1;
                    o_rel.vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_packet_byte = r_out_byte;
    assign o_last_byte   = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/ecgdpe_checker.sv
// ============================================================================
// ecgdpe_checker
// Port-level checks on the packet stream, bound to the encoder top level.
// ============================================================================
`default_nettype none

`include "ecg_delta_packet_encoder_core_macros.svh"

module ecgdpe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [ecgdpe_pkg::BYTE_W-1:0] o_packet_byte,
    input logic                          o_last_byte
);
    import ecgdpe_pkg::*;

    logic [PKT_CNT_W-1:0] r_bcnt;

    // position of the byte on offer within its packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_bcnt <= o_last_byte ? '0 : r_bcnt + PKT_CNT_W'(1);
        end
    end

    `ECGDPE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_packet_byte) && $stable(o_last_byte), "output request dropped or changed while stalled")
    `ECGDPE_ASSERT_IMP(a_last_pos, o_out_valid, o_last_byte == (r_bcnt == LAST_BYTE_IDX), "last byte flag not on the final packet byte")
    `ECGDPE_ASSERT_IMP(a_type_first, o_out_valid && (r_bcnt == '0), o_packet_byte == PKT_TYPE, "packet does not open with its type byte")
    `ECGDPE_ASSERT_IMP(a_code_range, o_out_valid && (r_bcnt == CODE_BYTE_IDX), (o_packet_byte != '0) && (o_packet_byte <= MAX_CODE), "scale code out of range")

endmodule

bind ecg_delta_packet_encoder_core ecgdpe_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_packet_byte (o_packet_byte),
    .o_last_byte   (o_last_byte)
);

`default_nettype wire

FILE: dv/ecg_delta_packet_encoder_core_test.sv
// ----------------------------------------------------------------------------
// ecg_delta_packet_encoder_core_test
// Self-checking bench for the ECG delta packet encoder. Samples are sent in
// groups of 14, and each accepted request goes through a local packet model.
// Every output byte is checked against the oldest predicted byte. The run
// passes through phases with no idling, an idle sender, a stalling receiver
// and both together. One long receiver hold lets the block fill up so that
// it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_delta_packet_encoder_core_test;
    import ecgdpe_pkg::*;

    localparam int SCALE_DIV    = 127;
    localparam int CODE_STEP    = 4;
    localparam int HOLD_CYCLES  = 800;
    localparam int HOLD_AFTER   = 2 * GROUP_LEN;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 7;

    typedef enum int {
        GRP_QUIET,
        GRP_WILD,
        GRP_FLAT,
        GRP_RAIL
    } t_grp_shape;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [ID_W-1:0]     id;
        logic [HR_W-1:0]     hr;
    } t_sample_req;

    typedef struct packed {
        logic [BYTE_W-1:0] pkt_byte;
        logic              last;
    } t_byte_exp;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [SAMPLE_W-1:0] i_sample     = '0;
    logic [ID_W-1:0]     i_data_id    = '0;
    logic [HR_W-1:0]     i_heart_rate = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [BYTE_W-1:0]   o_packet_byte;
    logic                o_last_byte;

    ecg_delta_packet_encoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .i_data_id     (i_data_id),
        .i_heart_rate  (i_heart_rate),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packet_byte (o_packet_byte),
        .o_last_byte   (o_last_byte)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_sample_req pending_reqs[$];
    t_byte_exp   packet_bytes_due[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int samples_taken  = 0;
    int cycle_count    = 0;
    int fail_count     = 0;
    logic in_fire_q    = 1'b0;

    // packet model state
    logic signed [SAMPLE_W-1:0] grp_samples [GROUP_LEN];
    int                         grp_fill     = 0;
    int                         peak_rise    = 0;
    int                         peak_fall    = 0;
    logic signed [SAMPLE_W-1:0] prior_sample = '0;

    function automatic void due_byte(input logic [BYTE_W-1:0] val, input logic last);
        t_byte_exp b;
        b.pkt_byte = val;
        b.last     = last;
        packet_bytes_due.push_back(b);
    endfunction

    task automatic encode_sample(input logic [SAMPLE_W-1:0] smp,
                                 input logic [ID_W-1:0] id,
                                 input logic [HR_W-1:0] hr);
        int step;
        int up;
        int dn;
        int scale;
        int code;
        int q;
        if (grp_fill == 0) begin
            peak_rise = 0;
            peak_fall = 0;
        end else begin
            step = int'($signed(smp)) - int'(prior_sample);
            if (step > peak_rise) peak_rise = step;
            if (step < peak_fall) peak_fall = step;
        end
        grp_samples[grp_fill] = $signed(smp);
        prior_sample = $signed(smp);
        grp_fill++;
        if (grp_fill < GROUP_LEN) return;
        grp_fill = 0;

        // both divisions truncate toward zero
        up    = 1 + peak_rise / SCALE_DIV;
        dn    = 1 - peak_fall / SCALE_DIV;
        scale = (up > dn) ? up : dn;
        code  = scale;
        if (code > int'(SCALE_KNEE)) begin
            code = int'(SCALE_KNEE) + (code - int'(SCALE_KNEE)) / CODE_STEP;
        end

        due_byte(PKT_TYPE, 1'b0);
        due_byte(id[15:8], 1'b0);
        due_byte(id[7:0], 1'b0);
        due_byte(BYTE_W'(code), 1'b0);
        due_byte(grp_samples[0][15:8], 1'b0);
        due_byte(grp_samples[0][7:0], 1'b0);
        for (int n = 1; n < GROUP_LEN; n++) begin
            q = (int'(grp_samples[n]) - int'(grp_samples[n-1])) / scale;
            due_byte(BYTE_W'(int'(BYTE_BIAS) + q), 1'b0);
        end
        due_byte(hr, 1'b1);
    endtask

    function automatic void queue_sample(input logic [SAMPLE_W-1:0] smp,
                                         input logic [ID_W-1:0] id,
                                         input logic [HR_W-1:0] hr);
        t_sample_req r;
        r.sample = smp;
        r.id     = id;
        r.hr     = hr;
        pending_reqs.push_back(r);
    endfunction

    // one group of random content in the given shape
    function automatic void queue_group(input t_grp_shape shape);
        int base;
        int amp;
        int val;
        base = int'($signed(16'($urandom)));
        amp  = 1 << $urandom_range(0, 12);
        val  = base;
        for (int n = 0; n < GROUP_LEN; n++) begin
            case (shape)
                GRP_QUIET: begin
                    if (n != 0) val = val + int'($urandom_range(0, 2 * amp)) - amp;
                end
                GRP_WILD: begin
                    val = int'($urandom);
                end
                GRP_FLAT: begin
                    val = base;
                end
                default: begin
                    val = $urandom_range(0, 1) ? 32767 : -32768;
                end
            endcase
            queue_sample(SAMPLE_W'(val), ID_W'($urandom), HR_W'($urandom));
        end
    endfunction

    function automatic void queue_random_groups(input int count);
        int pick;
        for (int g = 0; g < count; g++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      queue_group(GRP_QUIET);
            else if (pick < 80) queue_group(GRP_WILD);
            else if (pick < 85) queue_group(GRP_FLAT);
            else                queue_group(GRP_RAIL);
        end
    endfunction

    // sender: inputs change on the falling edge
    always @(negedge i_clk) begin
        t_sample_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire_q) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                i_sample     <= nxt.sample;
                i_data_id    <= nxt.id;
                i_heart_rate <= nxt.hr;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold once the directed groups are in
    always @(negedge i_clk) begin
        if (!hold_done && samples_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && (hold_left == 0) &&
                       ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: everything sampled on the rising edge
    always @(posedge i_clk) begin
        t_byte_exp want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            in_fire_q <= i_rst_n && i_in_valid && o_in_ready;
            if (i_rst_n && i_in_valid && o_in_ready) begin
                encode_sample(i_sample, i_data_id, i_heart_rate);
                samples_taken++;
            end
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (packet_bytes_due.size() == 0) begin
                    $error("packet_byte: expected none, actual %0d", o_packet_byte);
                    fail_count++;
                end else begin
                    want = packet_bytes_due.pop_front();
                    if (o_packet_byte !== want.pkt_byte) begin
                        $error("packet_byte: expected %0d, actual %0d",
                               want.pkt_byte, o_packet_byte);
                        fail_count++;
                    end
                    if (o_last_byte !== want.last) begin
                        $error("last_byte: expected %0d, actual %0d", want.last, o_last_byte);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // rails: full-scale swings, highest id and rate, largest scale
        for (int n = 0; n < GROUP_LEN; n++) begin
            queue_sample((n % 2) ? 16'sh7fff : 16'sh8000, 16'hffff, 8'hff);
        end
        // steps right at the scale code knee, lowest id and rate
        for (int n = 0; n < GROUP_LEN; n++) begin
            queue_sample((n % 2) ? 16'sd12700 : 16'sd0, 16'h0000, 8'h00);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            queue_random_groups(phase == 0 ? 6 : 7);
            while (pending_reqs.size() != 0) @(posedge i_clk);
        end

        while (pending_reqs.size() != 0 || i_in_valid || packet_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && packet_bytes_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ecgdpe_pkg.sv
rtl/ecgdpe_front.sv
rtl/ecgdpe_fifo.sv
rtl/ecgdpe_back.sv
rtl/ecg_delta_packet_encoder_core.sv
rtl/ecgdpe_checker.sv
dv/ecg_delta_packet_encoder_core_test.sv
